// ===== sv/i32div_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i32div_pkg
// Shared width and mode constants and the stage record of the pipelined integer divider.
// ----------------------------------------------------------------------------
package i32div_pkg;

  // Operand and result width.
  localparam int unsigned DATA_WIDTH = 32;

  // Division modes.
  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // One item as it travels down the divider pipeline.
  //   rem   partial remainder
  //   quo   remaining dividend bits on top, settled quotient bits below
  //   div   divisor magnitude
  //   neg_q negate the quotient at the end
  //   neg_r negate the remainder at the end
  typedef struct packed {
    logic  valid;
    word_t rem;
    word_t quo;
    word_t div;
    logic  neg_q;
    logic  neg_r;
  } stage_t;

endpackage

// ===== sv/i32div_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i32div_req_if
// Request channel of the divider: one item holds dividend, divisor and mode.
// ----------------------------------------------------------------------------
interface i32div_req_if;
  import i32div_pkg::*;

  logic  valid;
  logic  ready;
  word_t dividend;
  word_t divisor;
  logic  mode;

  modport source (output valid, output dividend, output divisor, output mode,
                  input ready);
  modport sink   (input valid, input dividend, input divisor, input mode,
                  output ready);
endinterface

// ===== sv/i32div_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i32div_rsp_if
// Response channel of the divider: one item holds quotient and remainder.
// ----------------------------------------------------------------------------
interface i32div_rsp_if;
  import i32div_pkg::*;

  logic  valid;
  logic  ready;
  word_t quotient;
  word_t remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== sv/i32div_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i32div_prep
// Entry stage: takes operand magnitudes and records the sign fix-up to apply.
// ----------------------------------------------------------------------------
module i32div_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  i32div_pkg::word_t   dividend,
  input  i32div_pkg::word_t   divisor,
  input  logic                mode,
  output i32div_pkg::stage_t  stg_out
);
  import i32div_pkg::*;

  logic   a_neg;
  logic   b_neg;
  word_t  a_mag;
  word_t  b_mag;
  stage_t stg_next;

  // In signed mode a negative operand is replaced by its two's complement.
  always_comb begin
    a_neg = (mode == MODE_SIGNED) && dividend[DATA_WIDTH-1];
    b_neg = (mode == MODE_SIGNED) && divisor[DATA_WIDTH-1];
    a_mag = a_neg ? word_t'(~dividend + 1'b1) : dividend;
    b_mag = b_neg ? word_t'(~divisor + 1'b1) : divisor;

    stg_next.valid = in_valid;
    stg_next.rem   = '0;
    stg_next.quo   = a_mag;
    stg_next.div   = b_mag;
    stg_next.neg_q = a_neg ^ b_neg;
    stg_next.neg_r = a_neg;
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_out.valid <= 1'b0;
    end else if (en) begin
      stg_out <= stg_next;
    end
  end

endmodule

// ===== sv/i32div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i32div_step
// One restoring division step: settles one quotient bit and registers it.
// ----------------------------------------------------------------------------
module i32div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  i32div_pkg::stage_t  stg_in,
  output i32div_pkg::stage_t  stg_out
);
  import i32div_pkg::*;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH+1:0] diff;
  logic                  borrow;
  stage_t                stg_next;

  // Shift the next dividend bit into the partial remainder and try to
  // subtract the divisor; keep the difference only when it does not borrow.
  always_comb begin
    trial  = {stg_in.rem, stg_in.quo[DATA_WIDTH-1]};
    diff   = {1'b0, trial} - {2'b00, stg_in.div};
    borrow = diff[DATA_WIDTH+1];

    stg_next     = stg_in;
    stg_next.rem = borrow ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
    stg_next.quo = {stg_in.quo[DATA_WIDTH-2:0], ~borrow};
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_out.valid <= 1'b0;
    end else if (en) begin
      stg_out <= stg_next;
    end
  end

endmodule

// ===== sv/i32div_fix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i32div_fix
// Exit stage: applies the sign fix-up and holds the result for the consumer.
// ----------------------------------------------------------------------------
module i32div_fix (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  i32div_pkg::stage_t  stg_in,
  i32div_rsp_if.source        rsp
);
  import i32div_pkg::*;

  word_t q_next;
  word_t r_next;

  // Negate the magnitudes where the operand signs call for it.
  always_comb begin
    q_next = stg_in.neg_q ? word_t'(~stg_in.quo + 1'b1) : stg_in.quo;
    r_next = stg_in.neg_r ? word_t'(~stg_in.rem + 1'b1) : stg_in.rem;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= stg_in.valid;
    end
    if (en) begin
      rsp.quotient  <= q_next;
      rsp.remainder <= r_next;
    end
  end

endmodule

// ===== sv/int32_divider_signed_unsigned.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_divider_signed_unsigned
// Pipelined 32-bit signed and unsigned divider giving quotient and remainder.
// ----------------------------------------------------------------------------
// Each item passes an entry stage that takes operand magnitudes, 32 restoring
// division stages that each settle one quotient bit, and an exit stage that
// fixes the signs. These are 34 register stages; the accepting edge loads the
// first, and the output register is the last.
// A new item can enter in every cycle; the whole pipeline holds while the
// output register is full and the consumer is not ready. Signed mode truncates
// toward zero and gives the remainder the sign of the dividend. A zero divisor
// returns the dividend as remainder and an all-ones quotient (plus one in
// signed mode with a negative dividend); the most negative value divided by
// minus one wraps to the most negative value.
module int32_divider_signed_unsigned (
  input logic           clk,
  input logic           rst,
  i32div_req_if.sink    req,
  i32div_rsp_if.source  rsp
);
  import i32div_pkg::*;

  logic   adv;
  stage_t pipe [0:DATA_WIDTH];

  // Every stage moves forward unless the output register is stalled.
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Operand preparation.
  i32div_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (req.valid),
    .dividend (req.dividend),
    .divisor  (req.divisor),
    .mode     (req.mode),
    .stg_out  (pipe[0])
  );

  // One division step per quotient bit.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    i32div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .stg_in  (pipe[i]),
      .stg_out (pipe[i+1])
    );
  end

  // Sign fix-up and output register.
  i32div_fix u_fix (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .stg_in (pipe[DATA_WIDTH]),
    .rsp    (rsp)
  );

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid after reset");

  // An item leaving the last step reaches the output register.
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    adv && pipe[DATA_WIDTH].valid |=> rsp.valid)
    else $error("item lost between last step and output");

  // After all steps the remainder is below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    pipe[DATA_WIDTH].valid |->
      (pipe[DATA_WIDTH].rem < pipe[DATA_WIDTH].div) || (pipe[DATA_WIDTH].div == '0))
    else $error("final remainder not below divisor");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 32-bit signed and unsigned integer divider.
// ----------------------------------------------------------------------------
// Dividend, divisor and mode items go in on the request channel. A behavioral
// divider in the bench predicts quotient and remainder for each accepted item
// and queues the pair. The checker compares every response item against the
// oldest queued pair. Directed cases cover the operand extremes, truncation
// toward zero, zero divisors and the most-negative-by-minus-one wrap. Random
// operands of mixed magnitudes follow. Both channels stall in random bursts,
// except in the final stretch, which runs at full rate.
module testbench;
  import i32div_pkg::*;

  // Expected quotient and remainder of one division.
  typedef struct {
    word_t quotient;
    word_t remainder;
  } div_result_t;

  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned FULL_RATE_ITEMS = 150;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic clk;
  logic rst;

  i32div_req_if req_ch ();
  i32div_rsp_if rsp_ch ();

  int32_divider_signed_unsigned dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  div_result_t pending_divisions[$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned zero_divisor_items;
  int unsigned signed_items;
  int unsigned cycle_count;
  int unsigned ready_stall_left;
  bit          idling_on;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predict quotient and remainder the way a restoring divider with a sign
  // fix-up step produces them.
  function automatic div_result_t compute_division(word_t dividend, word_t divisor,
                                                   logic mode);
    div_result_t res;
    logic        dividend_neg;
    logic        divisor_neg;
    word_t       num;
    word_t       den;
    dividend_neg = (mode == MODE_SIGNED) && dividend[DATA_WIDTH-1];
    divisor_neg  = (mode == MODE_SIGNED) && divisor[DATA_WIDTH-1];
    num = dividend_neg ? word_t'(-dividend) : dividend;
    den = divisor_neg ? word_t'(-divisor) : divisor;
    if (den == '0) begin
      res.quotient  = '1;
      res.remainder = num;
    end else begin
      res.quotient  = num / den;
      res.remainder = num % den;
    end
    if (dividend_neg != divisor_neg) begin
      res.quotient = word_t'(-res.quotient);
    end
    if (dividend_neg) begin
      res.remainder = word_t'(-res.remainder);
    end
    return res;
  endfunction

  // Count a failure and describe the first few of them.
  task automatic report_mismatch(string what, word_t want, word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Offer one item at a falling edge, hold it until it is accepted and queue
  // its prediction. Returns at the falling edge after acceptance.
  task automatic send_item(word_t dividend, word_t divisor, logic mode);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.dividend <= dividend;
    req_ch.divisor  <= divisor;
    req_ch.mode     <= mode;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_divisions.push_back(compute_division(dividend, divisor, mode));
    items_sent++;
    if (divisor == '0) zero_divisor_items++;
    if (mode == MODE_SIGNED) signed_items++;
    @(negedge clk);
  endtask

  // Operand of a random magnitude class: full range, tiny, near either end
  // of the signed or unsigned range, or a shifted random pattern.
  function automatic word_t random_operand();
    word_t value;
    case ($urandom_range(0, 5))
      0: value = word_t'($urandom_range(0, 15));
      1: value = word_t'(32'hFFFF_FFFF - $urandom_range(0, 15));
      2: value = word_t'(32'h8000_0000 + $urandom_range(0, 15));
      3: value = word_t'(32'h7FFF_FFFF - $urandom_range(0, 15));
      4: value = word_t'($urandom) >> $urandom_range(0, 31);
      default: value = word_t'($urandom);
    endcase
    return value;
  endfunction

  // Consumer side: ready drops in random bursts while idling is on.
  always @(negedge clk) begin
    if (idling_on && ready_stall_left > 0) begin
      ready_stall_left <= ready_stall_left - 1;
      rsp_ch.ready     <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      ready_stall_left <= $urandom_range(0, 6);
      rsp_ch.ready     <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted response item with the oldest prediction.
  always @(posedge clk) begin
    div_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_divisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("[%0t] response item with no division outstanding: q=%h r=%h",
                   $realtime, rsp_ch.quotient, rsp_ch.remainder);
        end
      end else begin
        want = pending_divisions.pop_front();
        results_checked++;
        if (rsp_ch.quotient !== want.quotient) begin
          report_mismatch("quotient", want.quotient, rsp_ch.quotient);
        end
        if (rsp_ch.remainder !== want.remainder) begin
          report_mismatch("remainder", want.remainder, rsp_ch.remainder);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d divisions outstanding",
               cycle_count, pending_divisions.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Plain unsigned division at the edges of the range.
  task automatic test_unsigned_extremes();
    send_item(32'h0000_0000, 32'h0000_0001, MODE_UNSIGNED);
    send_item(32'hFFFF_FFFF, 32'h0000_0001, MODE_UNSIGNED);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_UNSIGNED);
    send_item(32'h0000_0007, 32'hFFFF_FFFF, MODE_UNSIGNED);
    send_item(32'h1234_5678, 32'h0000_0010, MODE_UNSIGNED);
    send_item(32'h8000_0000, 32'h0000_0003, MODE_UNSIGNED);
  endtask

  // Signed division with one or both operands negative truncates toward zero.
  task automatic test_signed_truncation();
    send_item(word_t'(-7), 32'h0000_0002, MODE_SIGNED);
    send_item(32'h0000_0007, word_t'(-2), MODE_SIGNED);
    send_item(word_t'(-7), word_t'(-2), MODE_SIGNED);
    send_item(32'h8000_0000, 32'h0000_0001, MODE_SIGNED);
    send_item(32'h7FFF_FFFF, word_t'(-1), MODE_SIGNED);
    send_item(32'h8000_0000, 32'h8000_0000, MODE_SIGNED);
  endtask

  // A zero divisor returns the dividend; the quotient depends on mode and sign.
  task automatic test_zero_divisor();
    send_item(32'h0001_2345, 32'h0000_0000, MODE_UNSIGNED);
    send_item(32'hFFFF_FFFF, 32'h0000_0000, MODE_UNSIGNED);
    send_item(32'h0000_0000, 32'h0000_0000, MODE_UNSIGNED);
    send_item(32'h0000_0005, 32'h0000_0000, MODE_SIGNED);
    send_item(word_t'(-5), 32'h0000_0000, MODE_SIGNED);
    send_item(32'h0000_0000, 32'h0000_0000, MODE_SIGNED);
    send_item(32'h8000_0000, 32'h0000_0000, MODE_SIGNED);
  endtask

  // The most negative value over minus one wraps in signed mode.
  task automatic test_most_negative_wrap();
    send_item(32'h8000_0000, 32'hFFFF_FFFF, MODE_SIGNED);
    send_item(32'h8000_0000, 32'hFFFF_FFFF, MODE_UNSIGNED);
  endtask

  // Random operands in both modes; a few divisors are forced to zero.
  task automatic test_random_operands(int unsigned count);
    word_t divisor;
    for (int unsigned i = 0; i < count; i++) begin
      divisor = ($urandom_range(0, 31) == 0) ? word_t'(0) : random_operand();
      send_item(random_operand(), divisor, logic'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.dividend    = '0;
    req_ch.divisor     = '0;
    req_ch.mode        = MODE_UNSIGNED;
    rsp_ch.ready       = 1'b0;
    mismatch_count     = 0;
    items_sent         = 0;
    results_checked    = 0;
    zero_divisor_items = 0;
    signed_items       = 0;
    cycle_count        = 0;
    ready_stall_left   = 0;
    idling_on          = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_unsigned_extremes();
    test_signed_truncation();
    test_zero_divisor();
    test_most_negative_wrap();
    test_random_operands(RANDOM_ITEMS - FULL_RATE_ITEMS);

    // Final stretch at full rate on both sides.
    idling_on = 1'b0;
    test_random_operands(FULL_RATE_ITEMS);
    req_ch.valid <= 1'b0;

    wait (pending_divisions.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("divisions sent: %0d (%0d signed, %0d by zero), results checked: %0d",
             items_sent, signed_items, zero_divisor_items, results_checked);
    $display("mismatching fields or stray results: %0d", mismatch_count);
    if (mismatch_count == 0 && pending_divisions.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
